// ----- hdl/ogdi_pkg.sv -----
// Shared types and constants for the occupancy grid disk inflation block.
// No dependencies; imported by ogdi_walk and occupancy_grid_disk_inflation.
package ogdi_pkg;

  localparam int COORD_W = 10;
  localparam int DIM_W   = 9;
  localparam int CELL_W  = 8;
  localparam int RAD_W   = 4;
  localparam int CFG_W   = 9;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_INFLATE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_HEIGHT   = 2'd2,
    CFG_OCCUPIED = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_WALK
  } state_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OFF_MAP = 1'b1;

  localparam logic [RAD_W-1:0]  RADIUS_RST   = 4'd3;
  localparam logic [DIM_W-1:0]  WIDTH_RST    = 9'd256;
  localparam logic [DIM_W-1:0]  HEIGHT_RST   = 9'd256;
  localparam logic [CELL_W-1:0] OCCUPIED_RST = 8'd100;

  // one step of the inflation walk
  typedef struct packed {
    logic             hit;   // cell lies on the disk: write it
    logic             last;  // final cell of the window
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } walk_t;

endpackage

// ----- hdl/ogdi_walk.sv -----
// Inflation window walker: clamps the square window to the map and steps
// through it one cell per cycle, flagging cells inside the disk. Uses ogdi_pkg.
module ogdi_walk (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [ogdi_pkg::COORD_W-1:0]    centre_x,
  input  logic signed [ogdi_pkg::COORD_W-1:0]    centre_y,
  input  logic        [ogdi_pkg::DIM_W-1:0]      w_eff,
  input  logic        [ogdi_pkg::DIM_W-1:0]      h_eff,
  input  logic        [ogdi_pkg::RAD_W-1:0]      radius,
  output ogdi_pkg::walk_t                        walk
);
  import ogdi_pkg::*;

  logic                     active;
  logic [DIM_W-1:0]         walk_column;
  logic [DIM_W-1:0]         walk_row;
  logic [DIM_W-1:0]         x_lo, x_hi, y_hi;
  logic signed [COORD_W-1:0] cen_x, cen_y;

  logic [DIM_W-1:0]   x_lo_c, x_hi_c, y_lo_c, y_hi_c;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]   adx, ady;
  logic [2*RAD_W-1:0] sqx, sqy, r2;
  logic [2*RAD_W:0]   dist2;
  logic               near;

  // clamp a signed position to [0, lim-1]; lim is at least 1
  function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [COORD_W:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] top;
    top = lim - 1'b1;
    if (v[COORD_W])
      return '0;
    else if (v[COORD_W-1:0] > {1'b0, top})
      return top;
    else
      return v[DIM_W-1:0];
  endfunction

  always_comb begin
    x_lo_c = clamp_dim({centre_x[COORD_W-1], centre_x} - (COORD_W+1)'(radius), w_eff);
    x_hi_c = clamp_dim({centre_x[COORD_W-1], centre_x} + (COORD_W+1)'(radius), w_eff);
    y_lo_c = clamp_dim({centre_y[COORD_W-1], centre_y} - (COORD_W+1)'(radius), h_eff);
    y_hi_c = clamp_dim({centre_y[COORD_W-1], centre_y} + (COORD_W+1)'(radius), h_eff);
  end

  // far-off centres give large offsets; the square is taken only once in range
  always_comb begin
    dx    = $signed({2'b00, walk_column}) - $signed({cen_x[COORD_W-1], cen_x});
    dy    = $signed({2'b00, walk_row}) - $signed({cen_y[COORD_W-1], cen_y});
    adx   = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ady   = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    near  = (adx <= (COORD_W+1)'(radius)) && (ady <= (COORD_W+1)'(radius));
    sqx   = adx[RAD_W-1:0] * adx[RAD_W-1:0];
    sqy   = ady[RAD_W-1:0] * ady[RAD_W-1:0];
    r2    = radius * radius;
    dist2 = {1'b0, sqx} + {1'b0, sqy};
  end

  always_comb begin
    walk.col  = walk_column;
    walk.row  = walk_row;
    walk.hit  = active && near && (dist2 <= {1'b0, r2});
    walk.last = active && (walk_column == x_hi) && (walk_row == y_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      walk_column <= '0;
      walk_row    <= '0;
    end else if (start) begin
      active      <= 1'b1;
      walk_column <= x_lo_c;
      walk_row    <= y_lo_c;
    end else if (active) begin
      if (walk.last) begin
        active      <= 1'b0;
        walk_column <= '0;
        walk_row    <= '0;
      end else if (walk_column == x_hi) begin
        walk_column <= x_lo;
        walk_row    <= walk_row + 1'b1;
      end else begin
        walk_column <= walk_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_lo  <= x_lo_c;
      x_hi  <= x_hi_c;
      y_hi  <= y_hi_c;
      cen_x <= centre_x;
      cen_y <= centre_y;
    end
  end

endmodule

// ----- hdl/occupancy_grid_disk_inflation.sv -----
// Occupancy grid with circular obstacle inflation: top level, grid memory
// and command sequencer. Depends on ogdi_pkg and ogdi_walk.
//
// Usage: drive opcode, x_coord, y_coord and cell_data with start high; the
// command is taken on a clock edge where busy is low. Exactly one result
// follows, shown on read_value and status for the single cycle done is high.
// The receiver cannot hold results back.
// Path, from the accepting edge to done:
//   write, out-of-map read, no-op : ST_EXEC, then done
//   read inside the map           : ST_EXEC, then ST_RDWAIT, then done
//   inflate                       : ST_EXEC, then ST_WALK over the window,
//     the (2r+1) x (2r+1) square clamped to the map, one cell per cycle
//     through the single grid memory port (49 cells at r = 3).
// busy falls as done rises, so a new command may be accepted in the same
// cycle a result is delivered; one command is in flight at a time. The
// user must write configuration through cfg_we/cfg_index/cfg_wdata only
// while idle; the block does not check this. Reset (rst, synchronous) returns
// the sequencer to idle and the registers to their defaults; the grid
// contents are not cleared and every cell must be written before it is read.
module occupancy_grid_disk_inflation #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic signed [ogdi_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [ogdi_pkg::COORD_W-1:0]  y_coord,
  input  logic signed [ogdi_pkg::CELL_W-1:0]   cell_data,
  output logic                                 done,
  output logic signed [ogdi_pkg::CELL_W-1:0]   read_value,
  output logic                                 status,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ogdi_pkg::CFG_W-1:0]           cfg_wdata
);
  import ogdi_pkg::*;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int WLIM      = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int HLIM      = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;

  // configuration
  logic [RAD_W-1:0]  inflate_radius;
  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [CELL_W-1:0] occupied_value;

  // command registers
  state_t                    state, state_next;
  op_t                       op;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [CELL_W-1:0]         val_q;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;
  logic             on_grid, accept;

  // memory
  logic [CELL_W-1:0] grid_store [MEM_DEPTH];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [DIM_W-1:0]  mem_col, mem_row;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;

  // result control
  logic  res_set, res_status, res_from_mem, walk_start;
  walk_t walk;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflate_radius <= RADIUS_RST;
      grid_width     <= WIDTH_RST;
      grid_height    <= HEIGHT_RST;
      occupied_value <= OCCUPIED_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS:   inflate_radius <= cfg_wdata[RAD_W-1:0];
        CFG_WIDTH:    grid_width     <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT:   grid_height    <= cfg_wdata[DIM_W-1:0];
        CFG_OCCUPIED: occupied_value <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // map size: zero reads as one, saturate at store dims; radius max MAX_RADIUS
  always_comb begin
    if (grid_width == '0)
      w_eff = DIM_W'(1);
    else if (grid_width > DIM_W'(WLIM))
      w_eff = DIM_W'(WLIM);
    else
      w_eff = grid_width;
    if (grid_height == '0)
      h_eff = DIM_W'(1);
    else if (grid_height > DIM_W'(HLIM))
      h_eff = DIM_W'(HLIM);
    else
      h_eff = grid_height;
    if ({2'b00, inflate_radius} > 6'(MAX_RADIUS))
      r_eff = RAD_W'(MAX_RADIUS);
    else
      r_eff = inflate_radius;
  end

  assign on_grid = !x_q[COORD_W-1] && !y_q[COORD_W-1]
                && (x_q[DIM_W-1:0] < w_eff) && (y_q[DIM_W-1:0] < h_eff);
  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_t'(opcode);
      x_q   <= x_coord;
      y_q   <= y_coord;
      val_q <= cell_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        if (op == OP_INFLATE)
          state_next = ST_WALK;
        else if (op == OP_READ && on_grid)
          state_next = ST_RDWAIT;
        else
          state_next = ST_IDLE;
      end
      ST_RDWAIT: state_next = ST_IDLE;
      ST_WALK:   if (walk.last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_col      = x_q[DIM_W-1:0];
    mem_row      = y_q[DIM_W-1:0];
    mem_wdata    = val_q;
    walk_start   = 1'b0;
    res_set      = 1'b0;
    res_status   = STATUS_OK;
    res_from_mem = 1'b0;
    case (state)
      ST_EXEC: begin
        case (op)
          OP_WRITE: begin
            mem_we     = on_grid;
            res_set    = 1'b1;
            res_status = on_grid ? STATUS_OK : STATUS_OFF_MAP;
          end
          OP_READ: begin
            mem_re     = on_grid;
            res_set    = !on_grid;
            res_status = STATUS_OFF_MAP;
          end
          OP_INFLATE: walk_start = 1'b1;
          default:    res_set = 1'b1;
        endcase
      end
      ST_RDWAIT: begin
        res_set      = 1'b1;
        res_from_mem = 1'b1;
      end
      ST_WALK: begin
        mem_we    = walk.hit;
        mem_col   = walk.col;
        mem_row   = walk.row;
        mem_wdata = occupied_value;
        res_set   = walk.last;
      end
      default: ;
    endcase
  end

  assign mem_addr = AW'(AW'(mem_row) * AW'(MAX_WIDTH)) + AW'(mem_col);

  always_ff @(posedge clk) begin
    if (mem_we)
      grid_store[mem_addr] <= mem_wdata;
    if (mem_re)
      rd_data <= grid_store[mem_addr];
  end

  ogdi_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .centre_x (x_q),
    .centre_y (y_q),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .radius   (r_eff),
    .walk     (walk)
  );

  always_ff @(posedge clk) begin
    if (rst)
      done <= 1'b0;
    else
      done <= res_set;
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      status     <= res_status;
      read_value <= res_from_mem ? $signed(rd_data) : '0;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC || $past(state) == ST_RDWAIT
              || $past(state) == ST_WALK))
    else $error("result without a command in progress");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_EXEC || state == ST_WALK))
    else $error("grid write outside a write or inflation");

  a_walk_in_map: assert property (@(posedge clk) disable iff (rst)
    walk.hit |-> (walk.col < w_eff && walk.row < h_eff && state == ST_WALK))
    else $error("inflation write outside the map");

endmodule
